// ----- rtl/aqli_pkg.sv -----
// ----------------------------------------------------------------------------
// aqli_pkg: shared types and constants for the air quality LED indicator
// Register map, sequencer states, pollutant selectors and the ramp step.
// ----------------------------------------------------------------------------
`default_nettype none

package aqli_pkg;

  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;
  localparam int LevelW   = 8;
  localparam int ReadW    = 16;
  localparam int ProdW    = LevelW + ReadW;
  localparam int DivCntW  = $clog2(LevelW);

  // register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_LEDS_ON     = 3'd0,
    REG_FULL_LEVEL  = 3'd1,
    REG_BLINK_LEVEL = 3'd2,
    REG_CO2_LOW     = 3'd3,
    REG_CO2_HIGH    = 3'd4,
    REG_PM_LOW      = 3'd5,
    REG_PM_HIGH     = 3'd6
  } reg_idx_t;

  localparam logic              RST_LEDS_ON     = 1'b1;
  localparam logic [LevelW-1:0] RST_FULL_LEVEL  = 8'd32;
  localparam logic [LevelW-1:0] RST_BLINK_LEVEL = 8'd32;
  localparam logic [ReadW-1:0]  RST_CO2_LOW     = 16'd800;
  localparam logic [ReadW-1:0]  RST_CO2_HIGH    = 16'd1500;
  localparam logic [ReadW-1:0]  RST_PM_LOW      = 16'd10;
  localparam logic [ReadW-1:0]  RST_PM_HIGH     = 16'd50;

  // pollutant pair selector
  localparam logic POL_PM  = 1'b0;
  localparam logic POL_CO2 = 1'b1;

  // out_tuser bit positions
  localparam int WR_PM  = 0;
  localparam int WR_MID = 1;
  localparam int WR_CO2 = 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RAMP = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // one step of a brightness ramp toward its target
  function automatic logic [LevelW-1:0] ramp_step(input logic [LevelW-1:0] lvl,
                                                  input logic [LevelW-1:0] tgt);
    logic [LevelW-1:0] res;
    res = lvl;
    if (lvl > tgt) begin
      res = lvl - 1'b1;
    end else if (lvl < tgt) begin
      res = lvl + 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/air_quality_led_indicator_unit.sv -----
// ----------------------------------------------------------------------------
// air_quality_led_indicator_unit: LED color generator for an air quality node
// One refresh tick in, one set of LED pair colors out. Gradients are computed
// by a shared multiplier and an 8-step restoring divider under a sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in_      in   in_tvalid/in_tready     tdata: co2, pm; tuser: reset, pairing
//  out_     out  out_tvalid/out_tready   tdata: six levels; tuser: write flags
//  cfg_     in   APB psel/penable/pready register writes and reads
//
//  A tick goes from transfer to result register through a done state, plus
//  one ramp state per pollutant pair unless reset blink skips them, plus one
//  multiply state and 8 divide steps for each pair in the gradient band.
//  in_tready is high only while the sequencer is idle, which it enters in
//  the cycle after the result register loads.
//  A finished result waits in the output register while the next tick runs.
//  rst_n is synchronous: ramps clear, pulse phase sets, registers reload.
// ----------------------------------------------------------------------------
`default_nettype none

module air_quality_led_indicator_unit #(
  parameter int PULSE_TICKS = 50
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // co2_reading [15:0], pm_reading [31:16]
  input  wire logic [31:0] in_tdata,
  // reset_waiting [0], pairing_active [1]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pm_red [7:0], pm_green [15:8], mid_red [23:16], mid_blue [31:24],
  // co2_red [39:32], co2_green [47:40]
  output logic [47:0]      out_tdata,
  // pm_write [0], mid_write [1], co2_write [2]
  output logic [2:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [aqli_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [aqli_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [aqli_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int TickW = (PULSE_TICKS > 2) ? $clog2(PULSE_TICKS) : 1;
  localparam logic [TickW:0] TickWrap = (TickW+1)'(PULSE_TICKS);
  localparam logic [aqli_pkg::DivCntW-1:0] DivLast =
    aqli_pkg::DivCntW'(aqli_pkg::LevelW - 1);

  // configuration
  logic                        leds_on_r;
  logic [aqli_pkg::LevelW-1:0] full_level_r, blink_level_r;
  logic [aqli_pkg::ReadW-1:0]  co2_low_r, co2_high_r, pm_low_r, pm_high_r;

  // control and tick state
  aqli_pkg::state_t            state_r, state_nxt;
  logic                        sel_r;
  logic [TickW-1:0]            tick_r;
  logic                        pulse_r;
  logic [aqli_pkg::LevelW-1:0] ramp_r [2];
  logic [aqli_pkg::LevelW-1:0] pair_ramp_r;
  logic                        out_tvalid_r;

  // datapath
  logic [aqli_pkg::ReadW-1:0]  co2_r, pm_r;
  logic                        blink_r, pair_r;
  logic [aqli_pkg::LevelW-1:0] res_red_r [2];
  logic [aqli_pkg::LevelW-1:0] res_grn_r [2];
  logic                        res_wr_r [2];
  logic [aqli_pkg::LevelW-1:0] mul_a_r;
  logic [aqli_pkg::ReadW-1:0]  mul_b_r, div_d_r;
  logic                        grn_r;
  logic [aqli_pkg::ReadW-1:0]  rem_r;
  logic [aqli_pkg::LevelW-1:0] dq_r;
  logic [aqli_pkg::DivCntW-1:0] div_cnt_r;
  logic [47:0]                 out_tdata_r;
  logic [2:0]                  out_tuser_r;

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  logic                  cfg_wr;
  aqli_pkg::reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = aqli_pkg::reg_idx_t'(cfg_paddr[aqli_pkg::CfgAddrW-1:2]);

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      aqli_pkg::REG_LEDS_ON:     cfg_prdata = 32'(leds_on_r);
      aqli_pkg::REG_FULL_LEVEL:  cfg_prdata = 32'(full_level_r);
      aqli_pkg::REG_BLINK_LEVEL: cfg_prdata = 32'(blink_level_r);
      aqli_pkg::REG_CO2_LOW:     cfg_prdata = 32'(co2_low_r);
      aqli_pkg::REG_CO2_HIGH:    cfg_prdata = 32'(co2_high_r);
      aqli_pkg::REG_PM_LOW:      cfg_prdata = 32'(pm_low_r);
      aqli_pkg::REG_PM_HIGH:     cfg_prdata = 32'(pm_high_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Pollutant ramp and gradient setup
  // -------------------------------------------------------------------------
  logic                        in_xfer, out_free;
  logic [aqli_pkg::ReadW-1:0]  pv, plo, phi, pmid;
  logic                        p_above, p_low, p_high, p_below_mid, p_zero;
  logic [aqli_pkg::LevelW-1:0] p_tgt, p_lvl;

  assign in_tready = (state_r == aqli_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign pv   = (sel_r == aqli_pkg::POL_CO2) ? co2_r      : pm_r;
  assign plo  = (sel_r == aqli_pkg::POL_CO2) ? co2_low_r  : pm_low_r;
  assign phi  = (sel_r == aqli_pkg::POL_CO2) ? co2_high_r : pm_high_r;
  assign pmid = plo + ((phi - plo) >> 1);

  assign p_zero      = (pv == '0);
  assign p_above     = pv > phi;
  assign p_low       = pv <= plo;
  assign p_high      = pv >= phi;
  assign p_below_mid = pv < pmid;
  // above the high mark the target pulses with the phase
  assign p_tgt = (leds_on_r && (!p_above || pulse_r)) ? full_level_r : '0;
  assign p_lvl = aqli_pkg::ramp_step(ramp_r[sel_r], p_tgt);

  logic p_need_div;
  assign p_need_div = !p_zero && !p_above && !p_low && !p_high;

  // -------------------------------------------------------------------------
  // Shared multiplier and restoring divide step
  // -------------------------------------------------------------------------
  logic [aqli_pkg::ProdW-1:0]  prod;
  logic [aqli_pkg::ReadW:0]    div_trial;
  logic                        div_ge;
  logic [aqli_pkg::ReadW-1:0]  rem_step;
  logic [aqli_pkg::LevelW-1:0] dq_step;
  logic [aqli_pkg::ReadW:0]    div_diff;

  assign prod      = aqli_pkg::ProdW'(mul_a_r) * aqli_pkg::ProdW'(mul_b_r);
  assign div_trial = {rem_r, dq_r[aqli_pkg::LevelW-1]};
  assign div_ge    = div_trial >= {1'b0, div_d_r};
  assign div_diff  = div_trial - {1'b0, div_d_r};
  assign rem_step  = div_ge ? div_diff[aqli_pkg::ReadW-1:0]
                            : div_trial[aqli_pkg::ReadW-1:0];
  assign dq_step   = {dq_r[aqli_pkg::LevelW-2:0], div_ge};

  // -------------------------------------------------------------------------
  // Middle pair and tick
  // -------------------------------------------------------------------------
  logic                        blink_phase;
  logic                        mid_en;
  logic [aqli_pkg::LevelW-1:0] pair_lvl;
  logic [TickW:0]              tick_inc;
  logic                        tick_wrap;

  assign blink_phase = !pulse_r;
  assign mid_en   = pair_r || (pair_ramp_r != '0) || (co2_r == '0 && pm_r == '0);
  assign pair_lvl = aqli_pkg::ramp_step(pair_ramp_r,
                                        (leds_on_r && pulse_r) ? full_level_r : '0);
  assign tick_inc  = {1'b0, tick_r} + 1'b1;
  assign tick_wrap = tick_inc >= TickWrap;

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aqli_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_tuser[0] ? aqli_pkg::S_DONE : aqli_pkg::S_RAMP;
        end
      end
      aqli_pkg::S_RAMP: begin
        if (p_need_div) begin
          state_nxt = aqli_pkg::S_MUL;
        end else if (sel_r == aqli_pkg::POL_CO2) begin
          state_nxt = aqli_pkg::S_DONE;
        end
      end
      aqli_pkg::S_MUL: state_nxt = aqli_pkg::S_DIV;
      aqli_pkg::S_DIV: begin
        if (div_cnt_r == DivLast) begin
          state_nxt = (sel_r == aqli_pkg::POL_CO2) ? aqli_pkg::S_DONE
                                                   : aqli_pkg::S_RAMP;
        end
      end
      aqli_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = aqli_pkg::S_IDLE;
        end
      end
      default: state_nxt = aqli_pkg::S_IDLE;
    endcase
  end

  // control state, configuration and ramps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= aqli_pkg::S_IDLE;
      sel_r         <= aqli_pkg::POL_PM;
      tick_r        <= '0;
      pulse_r       <= 1'b1;
      ramp_r[0]     <= '0;
      ramp_r[1]     <= '0;
      pair_ramp_r   <= '0;
      out_tvalid_r  <= 1'b0;
      leds_on_r     <= aqli_pkg::RST_LEDS_ON;
      full_level_r  <= aqli_pkg::RST_FULL_LEVEL;
      blink_level_r <= aqli_pkg::RST_BLINK_LEVEL;
      co2_low_r     <= aqli_pkg::RST_CO2_LOW;
      co2_high_r    <= aqli_pkg::RST_CO2_HIGH;
      pm_low_r      <= aqli_pkg::RST_PM_LOW;
      pm_high_r     <= aqli_pkg::RST_PM_HIGH;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_idx)
          aqli_pkg::REG_LEDS_ON:     leds_on_r     <= cfg_pwdata[0];
          aqli_pkg::REG_FULL_LEVEL:  full_level_r  <= cfg_pwdata[7:0];
          aqli_pkg::REG_BLINK_LEVEL: blink_level_r <= cfg_pwdata[7:0];
          aqli_pkg::REG_CO2_LOW:     co2_low_r     <= cfg_pwdata[15:0];
          aqli_pkg::REG_CO2_HIGH:    co2_high_r    <= cfg_pwdata[15:0];
          aqli_pkg::REG_PM_LOW:      pm_low_r      <= cfg_pwdata[15:0];
          aqli_pkg::REG_PM_HIGH:     pm_high_r     <= cfg_pwdata[15:0];
          default: ;
        endcase
      end

      // load a new result, else drop the one just transferred
      if (state_r == aqli_pkg::S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        aqli_pkg::S_IDLE: begin
          sel_r <= aqli_pkg::POL_PM;
        end
        aqli_pkg::S_RAMP: begin
          // a zero reading holds its ramp
          if (!p_zero) begin
            ramp_r[sel_r] <= p_lvl;
          end
          if (!p_need_div) begin
            sel_r <= aqli_pkg::POL_CO2;
          end
        end
        aqli_pkg::S_DIV: begin
          if (div_cnt_r == DivLast) begin
            sel_r <= aqli_pkg::POL_CO2;
          end
        end
        aqli_pkg::S_DONE: begin
          if (out_free) begin
            if (blink_r) begin
              pulse_r <= blink_phase;
            end else begin
              if (mid_en) begin
                pair_ramp_r <= pair_lvl;
              end
              // phase is sampled above before the tick advances
              if (tick_wrap) begin
                tick_r  <= '0;
                pulse_r <= !pulse_r;
              end else begin
                tick_r <= tick_inc[TickW-1:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      aqli_pkg::S_IDLE: begin
        if (in_xfer) begin
          co2_r   <= in_tdata[15:0];
          pm_r    <= in_tdata[31:16];
          blink_r <= in_tuser[0];
          pair_r  <= in_tuser[1];
        end
      end
      aqli_pkg::S_RAMP: begin
        res_wr_r[sel_r] <= !p_zero;
        mul_a_r         <= p_lvl;
        if (p_zero) begin
          res_red_r[sel_r] <= '0;
          res_grn_r[sel_r] <= '0;
        end else if (p_above) begin
          res_red_r[sel_r] <= p_lvl;
          res_grn_r[sel_r] <= '0;
        end else if (p_low) begin
          res_red_r[sel_r] <= '0;
          res_grn_r[sel_r] <= p_lvl;
        end else if (p_high) begin
          res_red_r[sel_r] <= p_lvl;
          res_grn_r[sel_r] <= '0;
        end else if (p_below_mid) begin
          // red rises from low to mid
          res_grn_r[sel_r] <= p_lvl;
          mul_b_r          <= pv - plo;
          div_d_r          <= pmid - plo;
          grn_r            <= 1'b0;
        end else begin
          // green falls from mid to high
          res_red_r[sel_r] <= p_lvl;
          mul_b_r          <= phi - pv;
          div_d_r          <= phi - pmid;
          grn_r            <= 1'b1;
        end
      end
      aqli_pkg::S_MUL: begin
        // quotient fits the level width, so the upper product bits start below
        // the divisor
        rem_r     <= prod[aqli_pkg::ProdW-1:aqli_pkg::LevelW];
        dq_r      <= prod[aqli_pkg::LevelW-1:0];
        div_cnt_r <= '0;
      end
      aqli_pkg::S_DIV: begin
        rem_r     <= rem_step;
        dq_r      <= dq_step;
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_cnt_r == DivLast) begin
          if (grn_r) begin
            res_grn_r[sel_r] <= dq_step;
          end else begin
            res_red_r[sel_r] <= dq_step;
          end
        end
      end
      aqli_pkg::S_DONE: begin
        if (out_free) begin
          if (blink_r) begin
            out_tdata_r <= {16'd0, 8'd0, (blink_phase ? blink_level_r : 8'd0), 16'd0};
            out_tuser_r <= 3'b010;
          end else begin
            out_tdata_r <= {res_grn_r[1], res_red_r[1],
                            (mid_en ? pair_lvl : 8'd0), 8'd0,
                            res_grn_r[0], res_red_r[0]};
            out_tuser_r <= {res_wr_r[1], mid_en, res_wr_r[0]};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aqli_pkg::S_DIV) |-> (rem_r < div_d_r))
    else $error("divider remainder not below divisor");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aqli_pkg::S_DIV && div_cnt_r == DivLast) |-> (dq_step <= mul_a_r))
    else $error("gradient quotient exceeds ramp level");

  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aqli_pkg::S_MUL) |=> (state_r == aqli_pkg::S_DIV))
    else $error("multiply not followed by divide");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != aqli_pkg::S_IDLE))
    else $error("sequencer idle after input transfer");

  a_blink_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[23:16] != 8'd0) |->
      (out_tuser_r[aqli_pkg::WR_MID] && !out_tuser_r[aqli_pkg::WR_PM] &&
       !out_tuser_r[aqli_pkg::WR_CO2]))
    else $error("pollutant pair written during reset blink");

endmodule

`default_nettype wire
